// ----- hdl/bpsp_pkg.sv -----
// Package for the binary proof stream parser.
// Parse phases, event kinds, line-type bytes, register indexes and sign map.
// No dependencies.
`timescale 1ns / 1ps

package bpsp_pkg;

  localparam int LITERAL_BITS_DEF = 32;
  localparam int IDENT_BITS_DEF   = 64;

  localparam int VALUE_W     = 64;
  localparam int VARINT_MAXB = 10;  // bytes beyond this add nothing

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ORIG_ID,
    PH_ORIG_LITS,
    PH_ADD_ID,
    PH_ADD_LITS,
    PH_ADD_SEP,
    PH_ADD_HINTS,
    PH_OTHER_ID,
    PH_OTHER_LITS,
    PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    EV_ADD_ID = 3'd0,
    EV_LIT    = 3'd1,
    EV_HINT   = 3'd2,
    EV_DONE   = 3'd3,
    EV_END    = 3'd4,
    EV_ERROR  = 3'd5
  } event_kind_t;

  // line-type bytes
  localparam logic [7:0] CH_O = 8'h6F;
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_L = 8'h6C;

  localparam logic [7:0] VARINT_MORE = 8'b1000_0000;
  localparam logic [7:0] VARINT_DATA = 8'b0111_1111;

  // register indexes (paddr[2])
  localparam logic REG_LRAT_FORMAT  = 1'b0;
  localparam logic REG_LOOSE_ERRORS = 1'b1;

  typedef struct packed {
    logic take;   // byte goes into the decoder
    logic clear;  // drop the partial number
  } varint_ctl_t;

  // odd u -> -(u>>1), even u -> u>>1
  function automatic logic [VALUE_W-1:0] sign_map(input logic [VALUE_W-1:0] u);
    logic [VALUE_W-1:0] h;
    h = u >> 1;
    return u[0] ? (~h + {{(VALUE_W-1){1'b0}}, 1'b1}) : h;
  endfunction

endpackage

// ----- hdl/bpsp_varint.sv -----
// 7-bit little-endian varint accumulator for the proof stream parser.
// Depends on bpsp_pkg.
`timescale 1ns / 1ps

module bpsp_varint (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [7:0]                  data_byte,
  input  bpsp_pkg::varint_ctl_t       ctl,
  output logic                        done,
  output logic [bpsp_pkg::VALUE_W-1:0] value
);
  import bpsp_pkg::*;

  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [3:0]         pos_r, pos_nxt;
  logic [6:0]         shift_full;
  logic [VALUE_W-1:0] chunk;

  // 7*pos, at most 63 while pos < 10
  assign shift_full = {pos_r, 3'b000} - {3'b000, pos_r};
  assign chunk = {{(VALUE_W-7){1'b0}}, data_byte[6:0] & VARINT_DATA[6:0]}
                 << shift_full[5:0];

  assign value = (pos_r < 4'(VARINT_MAXB)) ? (acc_r | chunk) : acc_r;
  assign done  = (data_byte & VARINT_MORE) == 8'h00;

  always_comb begin
    acc_nxt = acc_r;
    pos_nxt = pos_r;
    if (ctl.clear || (ctl.take && done)) begin
      acc_nxt = '0;
      pos_nxt = '0;
    end else if (ctl.take) begin
      acc_nxt = value;
      if (pos_r < 4'(VARINT_MAXB)) begin
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      pos_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

// ----- hdl/binary_proof_stream_parser.sv -----
// Top level of the binary DRAT / LRAT / FRAT proof stream parser.
// Depends on bpsp_pkg and bpsp_varint.
`timescale 1ns / 1ps

// One byte enters per transfer: the phase logic and the varint decoder work
// straight off the input port, and any event lands in the output register
// in the cycle after the byte's transfer. Throughput is one byte per clock;
// in_ready drops only while an event waits in the output register and
// out_ready is low. Add lines yield the identifier, each literal, each hint
// and a done mark; o, d, r and t lines are consumed without events, though
// o, r and t are errors in LRAT mode. End of stream and parse errors (or end
// of stream in loose mode) halt the parser until reset; later bytes are
// taken and dropped. Registers: 0x0 lrat_format, 0x4 loose_errors, bit 0.

module binary_proof_stream_parser #(
  parameter int LITERAL_BITS = bpsp_pkg::LITERAL_BITS_DEF,
  parameter int IDENT_BITS   = bpsp_pkg::IDENT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_input,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic signed [63:0] out_event_value,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bpsp_pkg::*;

  // width masks for dropped high bits
  localparam logic [VALUE_W-1:0] LIT_MASK = {VALUE_W{1'b1}} >> (VALUE_W - LITERAL_BITS);
  localparam logic [VALUE_W-1:0] ID_MASK  = {VALUE_W{1'b1}} >> (VALUE_W - IDENT_BITS);

  // ---------------- configuration registers ----------------
  logic lrat_r, loose_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {31'b0, (paddr[2] == REG_LOOSE_ERRORS) ? loose_r : lrat_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lrat_r  <= 1'b0;
      loose_r <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_LRAT_FORMAT:  lrat_r  <= pwdata[0];
        REG_LOOSE_ERRORS: loose_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  logic out_valid_r, out_valid_nxt;
  logic [2:0] out_kind_r;
  logic [VALUE_W-1:0] out_value_r;
  logic in_xfer;

  // output register frees up in the same cycle its event is taken
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // ---------------- varint decoder ----------------
  varint_ctl_t        vctl;
  logic               v_done;
  logic [VALUE_W-1:0] v_value;

  bpsp_varint u_varint (
    .clk       (clk),
    .rst_n     (rst_n),
    .data_byte (in_data_byte),
    .ctl       (vctl),
    .done      (v_done),
    .value     (v_value)
  );

  logic [VALUE_W-1:0] id_u, lit_v, hint_v, add_v;
  assign id_u   = v_value & ID_MASK;
  assign lit_v  = sign_map(v_value & LIT_MASK);
  assign hint_v = sign_map(id_u);
  assign add_v  = lrat_r ? hint_v : id_u;  // FRAT ids are unsigned

  // ---------------- phase logic ----------------
  phase_t      phase_r, phase_nxt;
  logic        emit;
  event_kind_t ev_kind, fail_kind;
  logic [VALUE_W-1:0] ev_value;
  logic        fin;  // end or error: halt and drop partial number

  assign fail_kind = loose_r ? EV_END : EV_ERROR;

  always_comb begin
    phase_nxt  = phase_r;
    emit       = 1'b0;
    ev_kind    = EV_END;
    ev_value   = '0;
    fin        = 1'b0;
    vctl.take  = 1'b0;
    if (in_xfer && phase_r != PH_HALT) begin
      if (in_end_of_input) begin
        fin     = 1'b1;
        ev_kind = EV_END;
      end else begin
        case (phase_r)
          PH_IDLE: begin
            case (in_data_byte)
              CH_O: begin
                if (lrat_r) begin
                  fin = 1'b1; ev_kind = fail_kind;
                end else begin
                  phase_nxt = PH_ORIG_ID;
                end
              end
              CH_A: phase_nxt = PH_ADD_ID;
              CH_R, CH_T: begin
                if (lrat_r) begin
                  fin = 1'b1; ev_kind = fail_kind;
                end else begin
                  phase_nxt = PH_OTHER_ID;
                end
              end
              CH_D: phase_nxt = PH_OTHER_ID;
              CH_F: begin
                fin = 1'b1; ev_kind = EV_END;
              end
              default: begin
                fin = 1'b1; ev_kind = fail_kind;
              end
            endcase
          end
          PH_ORIG_ID: begin
            vctl.take = 1'b1;
            if (v_done) begin
              if (id_u == '0) begin
                fin = 1'b1; ev_kind = fail_kind;
              end else begin
                phase_nxt = PH_ORIG_LITS;
              end
            end
          end
          PH_ORIG_LITS, PH_OTHER_LITS: begin
            vctl.take = 1'b1;
            if (v_done && lit_v == '0) begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_OTHER_ID: begin
            vctl.take = 1'b1;
            if (v_done) begin
              phase_nxt = PH_OTHER_LITS;
            end
          end
          PH_ADD_ID: begin
            vctl.take = 1'b1;
            if (v_done) begin
              if (add_v == '0) begin
                fin = 1'b1; ev_kind = fail_kind;
              end else begin
                phase_nxt = PH_ADD_LITS;
                emit      = 1'b1;
                ev_kind   = EV_ADD_ID;
                ev_value  = add_v;
              end
            end
          end
          PH_ADD_LITS: begin
            vctl.take = 1'b1;
            if (v_done) begin
              if (lit_v == '0) begin
                phase_nxt = lrat_r ? PH_ADD_HINTS : PH_ADD_SEP;
              end else begin
                emit     = 1'b1;
                ev_kind  = EV_LIT;
                ev_value = lit_v;
              end
            end
          end
          PH_ADD_SEP: begin
            // FRAT: 'l' must follow the literal terminator
            if (in_data_byte != CH_L) begin
              fin = 1'b1; ev_kind = fail_kind;
            end else begin
              phase_nxt = PH_ADD_HINTS;
            end
          end
          PH_ADD_HINTS: begin
            vctl.take = 1'b1;
            if (v_done) begin
              emit = 1'b1;
              if (hint_v == '0) begin
                phase_nxt = PH_IDLE;
                ev_kind   = EV_DONE;
              end else begin
                ev_kind  = EV_HINT;
                ev_value = hint_v;
              end
            end
          end
          default: phase_nxt = PH_HALT;
        endcase
      end
      if (fin) begin
        phase_nxt = PH_HALT;
        emit      = 1'b1;
        ev_value  = '0;
      end
    end
    vctl.clear = fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload loads only with a new event
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r  <= ev_kind;
      out_value_r <= ev_value;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = out_kind_r;
  assign out_event_value = out_value_r;

endmodule

// ----- hdl/bpsp_checker.sv -----
// Port-level checker for the proof stream parser, with its bind.
// Depends on bpsp_pkg and binary_proof_stream_parser.
`timescale 1ns / 1ps

module bpsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_event_kind,
  input logic [63:0] out_event_value
);
  import bpsp_pkg::*;

  logic kind_final, kind_zero;
  assign kind_final = (out_event_kind == EV_END) || (out_event_kind == EV_ERROR);
  assign kind_zero  = kind_final || (out_event_kind == EV_DONE);

  // stalled event holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_kind)
                                && $stable(out_event_value))
    else $error("stalled event changed");

  // input side never blocked when the output slot is free
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("in_ready low with free output slot");

  // end or error transfer is the last event
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && kind_final |=> !out_valid)
    else $error("event after end of stream");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind_zero |-> out_event_value == 64'd0)
    else $error("nonzero value on done, end or error");

  a_add_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_ADD_ID |-> out_event_value != 64'd0)
    else $error("zero add identifier emitted");

endmodule

bind binary_proof_stream_parser bpsp_checker u_bpsp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_event_kind  (out_event_kind),
  .out_event_value (out_event_value)
);
